FILE: hdl/note_loop_recorder_overdub_macros.svh
// assertion macros shared by the checker
`ifndef NOTE_LOOP_RECORDER_OVERDUB_MACROS_SVH
`define NOTE_LOOP_RECORDER_OVERDUB_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define NLRO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on the rising clock edge
`define NLRO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hdl/nlro_pkg.sv
// ----------------------------------------------------------------------------
// nlro_pkg
// Shared types and constants of the note loop recorder.
// ----------------------------------------------------------------------------
`default_nettype none

package nlro_pkg;

  // results per tick are capped at this count
  localparam logic [6:0]  MAX_RESULTS = 7'd64;
  localparam logic [15:0] LOOP_RESET  = 16'd4800;
  localparam logic [2:0]  OCT_LOW     = 3'd4;
  localparam logic [2:0]  OCT_HIGH    = 3'd6;

  // item command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  // one stored event
  typedef struct packed {
    logic [15:0] stamp;
    logic        kind;
    logic [2:0]  octave;
    logic [3:0]  note;
  } nlro_entry_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic clear_all;
    logic emit_rall;
    logic rec_write;
    logic scan_init;
    logic scan_take;
    logic emit_last;
    logic adv;
    logic rec_clear;
    logic merge_start;
    logic merge_step;
    logic merge_finish;
    logic merge_sel;
  } nlro_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fall;
    logic en;
    logic is_key;
    logic scan_more;
    logic due;
    logic oct_ok;
    logic held_valid;
    logic out_free;
    logic wrap;
    logic merge_ok;
    logic merge_done;
  } nlro_status_t;

endpackage

`default_nettype wire

FILE: hdl/nlro_ctrl.sv
// ----------------------------------------------------------------------------
// nlro_ctrl
// Sequencer for capture, key recording, release-all, playback scan, loop wrap and record merge.
// ----------------------------------------------------------------------------
`default_nettype none

module nlro_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire nlro_pkg::nlro_status_t sts,
  output nlro_pkg::nlro_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    IDLE, DEC, RALL, P_RD, P_CHK, P_FIN, ADV, WRAP, M_RD, M_WR
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd_o      = '0;
    cmd_o.merge_sel = (state == M_RD) || (state == M_WR);
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd_o.cap  = 1'b1;
          state_next = DEC;
        end
      end
      DEC: begin
        if (sts.fall) begin
          cmd_o.clear_all = 1'b1;
          state_next      = RALL;
        end else if (!sts.en) begin
          state_next = IDLE;
        end else if (sts.is_key) begin
          cmd_o.rec_write = 1'b1;
          state_next      = IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_next      = P_RD;
        end
      end
      RALL: begin
        if (sts.out_free) begin
          cmd_o.emit_rall = 1'b1;
          state_next      = IDLE;
        end
      end
      P_RD: begin
        state_next = sts.scan_more ? P_CHK : P_FIN;
      end
      P_CHK: begin
        if (!sts.due) begin
          state_next = P_FIN;
        end else if (!(sts.oct_ok && sts.held_valid && !sts.out_free)) begin
          cmd_o.scan_take = 1'b1;
          state_next      = P_RD;
        end
      end
      P_FIN: begin
        if (!sts.held_valid) begin
          state_next = ADV;
        end else if (sts.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_next      = ADV;
        end
      end
      ADV: begin
        cmd_o.adv  = 1'b1;
        state_next = WRAP;
      end
      WRAP: begin
        if (!sts.wrap) begin
          state_next = IDLE;
        end else if (sts.merge_ok) begin
          cmd_o.merge_start = 1'b1;
          state_next        = M_RD;
        end else begin
          cmd_o.rec_clear = 1'b1;
          state_next      = IDLE;
        end
      end
      M_RD: begin
        if (sts.merge_done) begin
          cmd_o.merge_finish = 1'b1;
          state_next         = IDLE;
        end else begin
          state_next = M_WR;
        end
      end
      M_WR: begin
        cmd_o.merge_step = 1'b1;
        state_next       = M_RD;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/nlro_datapath.sv
// ----------------------------------------------------------------------------
// nlro_datapath
// Event stores, counters, loop position and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nlro_datapath #(
  parameter int EVENT_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire nlro_pkg::nlro_cmd_t    cmd_i,
  output nlro_pkg::nlro_status_t      sts,
  input  wire logic                   cfg_wr_en,
  input  wire logic [15:0]            cfg_wr_data,
  input  wire logic                   cmd,
  input  wire logic                   enabled,
  input  wire logic                   kind,
  input  wire logic [2:0]             octave,
  input  wire logic [3:0]             note_index,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        is_press,
  output logic [2:0]                  out_octave,
  output logic [3:0]                  out_note,
  output logic                        release_all,
  output logic                        last
);

  localparam int AW = $clog2(EVENT_DEPTH);
  localparam int CW = $clog2(EVENT_DEPTH + 1);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(EVENT_DEPTH);

  nlro_pkg::nlro_entry_t play_mem0 [EVENT_DEPTH];
  nlro_pkg::nlro_entry_t play_mem1 [EVENT_DEPTH];
  nlro_pkg::nlro_entry_t rec_mem   [EVENT_DEPTH];
  nlro_pkg::nlro_entry_t rd0, rd1, rec_rd, p_rd, held, pick;

  logic [15:0]   loop_length, pos, pos_inc;
  logic [CW-1:0] pc, rc, ptr, mi, mj, mk;
  logic [6:0]    n;
  logic          bank, was_en, fall_r, wrap_r, held_valid;
  logic          cmd_r, en_r, kind_r;
  logic [2:0]    oct_r;
  logic [3:0]    note_r;
  logic          take_p, load_out;
  logic [CW:0]   sum;
  logic [CW-1:0] p_addr;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= nlro_pkg::LOOP_RESET;
    end else if (cfg_wr_en) begin
      loop_length <= cfg_wr_data;
    end
  end

  // captured input transaction
  always_ff @(posedge clk) begin
    if (cmd_i.cap) begin
      cmd_r  <= cmd;
      en_r   <= enabled;
      kind_r <= kind;
      oct_r  <= octave;
      note_r <= note_index;
    end
  end

  // play store banks, registered read
  assign p_addr = cmd_i.merge_sel ? mi : ptr;
  always_ff @(posedge clk) begin
    if (cmd_i.merge_step && bank) begin
      play_mem0[mk[AW-1:0]] <= pick;
    end
    rd0 <= play_mem0[p_addr[AW-1:0]];
  end
  always_ff @(posedge clk) begin
    if (cmd_i.merge_step && !bank) begin
      play_mem1[mk[AW-1:0]] <= pick;
    end
    rd1 <= play_mem1[p_addr[AW-1:0]];
  end
  assign p_rd = bank ? rd1 : rd0;

  // record store, registered read
  always_ff @(posedge clk) begin
    if (cmd_i.rec_write && (rc < CW'(EVENT_DEPTH))) begin
      rec_mem[rc[AW-1:0]] <= {pos, kind_r, oct_r, note_r};
    end
    rec_rd <= rec_mem[mj[AW-1:0]];
  end

  // merge pick, play side first on equal stamps
  assign take_p = (mj == rc) || ((mi < pc) && (p_rd.stamp <= rec_rd.stamp));
  assign pick   = take_p ? p_rd : rec_rd;
  assign sum    = {1'b0, pc} + {1'b0, rc};
  assign pos_inc = pos + 16'd1;

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0; rc <= '0; pos <= '0; ptr <= '0; bank <= 1'b0;
      was_en <= 1'b0; fall_r <= 1'b0; wrap_r <= 1'b0;
      held_valid <= 1'b0; n <= '0; mi <= '0; mj <= '0; mk <= '0;
    end else begin
      if (cmd_i.cap) begin
        fall_r <= was_en & ~enabled;
        was_en <= enabled;
      end
      if (cmd_i.clear_all) begin
        pc <= '0; rc <= '0; pos <= '0; ptr <= '0;
      end
      if (cmd_i.rec_write && (rc < CW'(EVENT_DEPTH))) begin
        rc <= rc + CW'(1);
      end
      if (cmd_i.scan_init) begin
        n <= '0;
        held_valid <= 1'b0;
      end
      if (cmd_i.scan_take) begin
        ptr <= ptr + CW'(1);
        if (sts.oct_ok) begin
          held       <= p_rd;
          held_valid <= 1'b1;
          n          <= n + 7'd1;
        end
      end
      if (cmd_i.emit_last) begin
        held_valid <= 1'b0;
      end
      if (cmd_i.adv) begin
        wrap_r <= (pos_inc >= loop_length) || (pos_inc == 16'd0);
        if ((pos_inc >= loop_length) || (pos_inc == 16'd0)) begin
          pos <= '0;
          ptr <= '0;
        end else begin
          pos <= pos_inc;
        end
      end
      if (cmd_i.rec_clear) begin
        rc <= '0;
      end
      if (cmd_i.merge_start) begin
        mi <= '0; mj <= '0; mk <= '0;
      end
      if (cmd_i.merge_step) begin
        mk <= mk + CW'(1);
        if (take_p) begin
          mi <= mi + CW'(1);
        end else begin
          mj <= mj + CW'(1);
        end
      end
      if (cmd_i.merge_finish) begin
        pc   <= sum[CW-1:0];
        rc   <= '0;
        bank <= ~bank;
      end
    end
  end

  // result register
  assign load_out = cmd_i.emit_rall || cmd_i.emit_last ||
                    (cmd_i.scan_take && sts.oct_ok && held_valid);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd_i.emit_rall) begin
      is_press <= 1'b0; out_octave <= '0; out_note <= '0;
      release_all <= 1'b1; last <= 1'b1;
    end else if (load_out) begin
      is_press <= held.kind; out_octave <= held.octave; out_note <= held.note;
      release_all <= 1'b0; last <= cmd_i.emit_last;
    end
  end

  // status to the controller
  always_comb begin
    sts            = '0;
    sts.fall       = fall_r;
    sts.en         = en_r;
    sts.is_key     = (cmd_r == nlro_pkg::CMD_KEY);
    sts.scan_more  = (ptr < pc) && (n < nlro_pkg::MAX_RESULTS);
    sts.due        = (p_rd.stamp <= pos);
    sts.oct_ok     = (p_rd.octave >= nlro_pkg::OCT_LOW) &&
                     (p_rd.octave <= nlro_pkg::OCT_HIGH);
    sts.held_valid = held_valid;
    sts.out_free   = !out_valid || !out_stall;
    sts.wrap       = wrap_r;
    sts.merge_ok   = (rc != '0) && (sum <= DEPTH_W);
    sts.merge_done = (mi == pc) && (mj == rc);
  end

endmodule

`default_nettype wire

FILE: hdl/note_loop_recorder_overdub.sv
// A loop recorder for key events. Each input transaction is either a one
// millisecond tick or a key event; key events are stored with the loop
// position and replayed on later passes of the loop, only for octaves four
// to six. A tick scans the stored events, replaying or stepping over each
// one that is due, and stops at the first that is not yet due; result side
// stalls hold the scan. A falling enable edge clears the stores and sends a
// release-all result once the result side is free. At loop end the recorded
// events are merged into the sorted play store by a sequencer that reads and
// writes each event in turn (one registered read, one write), if they fit;
// otherwise the recorded events are dropped.
// ----------------------------------------------------------------------------
// note_loop_recorder_overdub
// Top level: controller plus datapath for the key event loop recorder.
// ----------------------------------------------------------------------------
`default_nettype none

module note_loop_recorder_overdub #(
  parameter int EVENT_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic        enabled,
  input  wire logic        kind,
  input  wire logic [2:0]  octave,
  input  wire logic [3:0]  note_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_press,
  output logic [2:0]       out_octave,
  output logic [3:0]       out_note,
  output logic             release_all,
  output logic             last
);

  nlro_pkg::nlro_cmd_t    cmd_bus;
  nlro_pkg::nlro_status_t sts_bus;

  // sequencer
  nlro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts_bus),
    .cmd_o    (cmd_bus)
  );

  // stores and counters
  nlro_datapath #(.EVENT_DEPTH(EVENT_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd_i       (cmd_bus),
    .sts         (sts_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .enabled     (enabled),
    .kind        (kind),
    .octave      (octave),
    .note_index  (note_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_press    (is_press),
    .out_octave  (out_octave),
    .out_note    (out_note),
    .release_all (release_all),
    .last        (last)
  );

endmodule

`default_nettype wire

FILE: hdl/nlro_checker.sv
// ----------------------------------------------------------------------------
// nlro_port_checker
// Port-level checks of the loop recorder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "note_loop_recorder_overdub_macros.svh"

module nlro_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        is_press,
  input wire logic [2:0]  out_octave,
  input wire logic [3:0]  out_note,
  input wire logic        release_all,
  input wire logic        last
);

  logic       rall_blank;
  logic       oct_audible;
  logic [9:0] out_word;

  // result field summaries
  assign rall_blank  = last && !is_press && (out_octave == 3'd0) && (out_note == 4'd0);
  assign oct_audible = (out_octave >= nlro_pkg::OCT_LOW) && (out_octave <= nlro_pkg::OCT_HIGH);
  assign out_word    = {is_press, out_octave, out_note, release_all, last};

  // a release_all transaction is a lone, blank, final result
  `NLRO_ASSERT_NOW(rall_shape, out_valid && release_all, rall_blank)

  // replayed events only come from the audible octaves
  `NLRO_ASSERT_NOW(oct_range, out_valid && !release_all, oct_audible)

  // the block is busy the cycle after it takes a transaction
  `NLRO_ASSERT_NEXT(busy_after_accept, in_valid && !in_stall, in_stall)

  // a stalled result holds
  `NLRO_ASSERT_NEXT(out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind note_loop_recorder_overdub nlro_port_checker u_nlro_port_checker (.*);

`default_nettype wire
